@@ sv/bda_pkg.sv @@
// shared types, codes and calendar functions for the business day adjuster
`timescale 1ns / 1ps
package bda_pkg;

   localparam logic [1:0] OP_WRITE_SLOT = 2'd0;
   localparam logic [1:0] OP_SHIFT      = 2'd1;
   localparam logic [1:0] OP_ROLL       = 2'd2;

   localparam logic [1:0] CONV_MOD_FOLLOWING = 2'd0;
   localparam logic [1:0] CONV_MOD_PRECEDING = 2'd1;
   localparam logic [1:0] CONV_FOLLOWING     = 2'd2;
   localparam logic [1:0] CONV_PRECEDING     = 2'd3;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_SLOT  = 2'd1;
   localparam logic [1:0] STATUS_LIMIT = 2'd2;

   // floor(y / 25) for 12-bit y as (y * 5243) >> 17
   localparam logic [12:0] DIV25_RECIP = 13'd5243;
   localparam int          DIV25_SHIFT = 17;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } date_type;

   typedef struct packed {
      logic        valid;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
   } hol_entry_type;

   typedef struct packed {
      logic done;
      logic hit;
   } scan_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_TEST,
      ST_WALK,
      ST_SCAN
   } state_type;

   typedef enum logic [1:0] {
      PH_SHIFT,
      PH_FIRST,
      PH_SECOND
   } phase_type;

   function automatic logic is_leap(input logic [11:0] y);
      logic [24:0] prod;
      logic [7:0]  quot;
      logic [12:0] back;
      logic        div25;
      prod  = {13'd0, y} * {12'd0, DIV25_RECIP};
      quot  = prod[DIV25_SHIFT +: 8];
      back  = {5'd0, quot} * 13'd25;
      div25 = (back == {1'b0, y});
      // divisible by 100 reduces to divisible by 4 and by 25, 400 to 16 and 25
      return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
   endfunction

   function automatic logic [4:0] days_of(input logic [11:0] y, input logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd2:                              len = is_leap(y) ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:           len = 5'd30;
         default:                           len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

@@ sv/bda_day_unit.sv @@
// one calendar day step forward or backward with real month lengths
`timescale 1ns / 1ps
module bda_day_unit (
   input  bda_pkg::date_type cur,
   input  logic              forward,
   output bda_pkg::date_type next
);
   import bda_pkg::*;

   logic        first_month;
   logic [3:0]  prev_month;
   logic [11:0] prev_year;
   logic [3:0]  len_month;
   logic [11:0] len_year;
   logic [4:0]  month_len;

   always_comb begin
      first_month = (cur.month <= 4'd1);
      prev_month  = first_month ? 4'd12 : cur.month - 4'd1;
      prev_year   = first_month ? cur.year - 12'd1 : cur.year;
      // backward steps need the length of the month being entered
      len_month   = forward ? cur.month : prev_month;
      len_year    = forward ? cur.year : prev_year;
      month_len   = days_of(len_year, len_month);
   end

   always_comb begin
      next = cur;
      if (forward) begin
         if (cur.day >= month_len) begin
            next.day = 5'd1;
            if (cur.month >= 4'd12) begin
               next.month = 4'd1;
               next.year  = cur.year + 12'd1;
            end else begin
               next.month = cur.month + 4'd1;
            end
         end else begin
            next.day = cur.day + 5'd1;
         end
      end else begin
         if (cur.day <= 5'd1) begin
            next.month = prev_month;
            next.year  = prev_year;
            next.day   = month_len;
         end else begin
            next.day = cur.day - 5'd1;
         end
      end
   end

endmodule

@@ sv/bda_hol_table.sv @@
// holiday table memory with clearing pass and sequential match scan
`timescale 1ns / 1ps
module bda_hol_table #(
   parameter int HOLIDAY_SLOTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [5:0]               wr_slot,
   input  bda_pkg::hol_entry_type   wr_entry,
   input  logic                     scan_start,
   input  bda_pkg::date_type        probe,
   output logic                     ready,
   output bda_pkg::scan_status_type scan
);
   import bda_pkg::*;

   localparam int IW = (HOLIDAY_SLOTS > 1) ? $clog2(HOLIDAY_SLOTS) : 1;
   localparam int CW = $clog2(HOLIDAY_SLOTS + 1);
   localparam logic [IW-1:0] LAST_SLOT = IW'(HOLIDAY_SLOTS - 1);

   hol_entry_type mem [HOLIDAY_SLOTS];
   hol_entry_type rd_ff;

   logic          clr_active_ff, clr_active_in;
   logic [IW-1:0] clr_idx_ff, clr_idx_in;
   logic [CW-1:0] high_ff, high_in;
   logic          active_ff, active_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic          wr_hit;
   logic [IW-1:0] wr_addr;
   logic [CW-1:0] slot_top;
   logic          issue;
   logic          match;
   logic          done;

   always_comb begin
      wr_hit   = wr_en && (int'(wr_slot) < HOLIDAY_SLOTS);
      wr_addr  = IW'(wr_slot);
      slot_top = CW'(wr_slot) + CW'(1);
      issue    = active_ff && (idx_ff < high_ff);
      match    = rd_ff.valid && (rd_ff.year == probe.year) &&
                 (rd_ff.month == probe.month) && (rd_ff.day == probe.day);
      // first active cycle has nothing pending; an empty table ends at once
      done     = active_ff && (pend_ff ? (match || !issue) : !issue);
      scan.done = done;
      scan.hit  = done && pend_ff && match;
      ready     = !clr_active_ff;
   end

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_idx_in    = clr_idx_ff;
      if (clr_active_ff) begin
         clr_idx_in = clr_idx_ff + IW'(1);
         if (clr_idx_ff == LAST_SLOT) begin
            clr_active_in = 1'b0;
         end
      end
      high_in = high_ff;
      if (wr_hit && (slot_top > high_ff)) begin
         high_in = slot_top;
      end
      active_in = active_ff;
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      if (scan_start) begin
         active_in = 1'b1;
         pend_in   = 1'b0;
         idx_in    = '0;
      end else if (done) begin
         active_in = 1'b0;
         pend_in   = 1'b0;
      end else begin
         pend_in = issue;
         if (issue) begin
            idx_in = idx_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_idx_ff    <= '0;
         high_ff       <= '0;
         active_ff     <= 1'b0;
         pend_ff       <= 1'b0;
         idx_ff        <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_idx_ff    <= clr_idx_in;
         high_ff       <= high_in;
         active_ff     <= active_in;
         pend_ff       <= pend_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_active_ff) begin
         mem[clr_idx_ff] <= '0;
      end else if (wr_hit) begin
         mem[wr_addr] <= wr_entry;
      end
      if (issue) begin
         rd_ff <= mem[idx_ff[IW-1:0]];
      end
   end

endmodule

@@ sv/business_day_adjuster.sv @@
// business day adjuster top level: sequencer, date registers and result strobe
// A transaction is taken when start is high and busy is low. A slot write
// (opcode 0) answers on the next cycle and leaves busy low. A shift or roll
// walks one calendar day at a time through a single day-step unit, and every
// walked date is checked against the holiday memory one entry per cycle over
// up to H entries, where H is one more than the highest holiday slot ever
// written (0 if none). The walk stops after STEP_LIMIT calendar days with
// status 2. After reset the block clears its holiday memory and keeps busy
// high through the clearing pass. Each result is shown for exactly one cycle
// with rsp_valid high; the receiver cannot hold it off, so it must take every
// result as it comes.
`timescale 1ns / 1ps
module business_day_adjuster #(
   parameter int HOLIDAY_SLOTS = 64,
   parameter int STEP_LIMIT    = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [5:0]         req_slot,
   input  logic               req_slot_valid,
   input  logic [11:0]        req_in_year,
   input  logic [3:0]         req_in_month,
   input  logic [4:0]         req_in_day,
   input  logic signed [11:0] req_day_gap,
   input  logic [1:0]         req_convention,
   output logic               rsp_valid,
   output logic [11:0]        rsp_out_year,
   output logic [3:0]         rsp_out_month,
   output logic [4:0]         rsp_out_day,
   output logic [1:0]         rsp_status
);
   import bda_pkg::*;

   localparam int SLW = $clog2(STEP_LIMIT + 1);
   localparam logic [SLW-1:0] LIMIT = SLW'(STEP_LIMIT);

   state_type       state_ff, state_in;
   phase_type       phase_ff, phase_in;
   date_type        cur_ff, cur_in;
   date_type        ref_ff, ref_in;
   logic            fwd_ff, fwd_in;
   logic            mod_ff, mod_in;
   logic [11:0]     rem_ff, rem_in;
   logic [SLW-1:0]  steps_ff, steps_in;
   logic            rsp_valid_ff, rsp_valid_in;
   date_type        rsp_date_ff, rsp_date_in;
   logic [1:0]      rsp_status_ff, rsp_status_in;

   date_type        clean;
   date_type        step_next;
   logic [3:0]      month_c;
   logic [4:0]      lim;
   logic            gap_pos;
   logic            walk_end;
   logic            walk_limit;
   logic            need_retry;
   logic            accept;
   logic            tbl_ready;
   logic            wr_en;
   logic            scan_start;
   hol_entry_type   wr_entry;
   scan_status_type scan;

   bda_hol_table #(
      .HOLIDAY_SLOTS(HOLIDAY_SLOTS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_slot    (req_slot),
      .wr_entry   (wr_entry),
      .scan_start (scan_start),
      .probe      (cur_ff),
      .ready      (tbl_ready),
      .scan       (scan)
   );

   bda_day_unit u_day (
      .cur     (cur_ff),
      .forward (fwd_ff),
      .next    (step_next)
   );

   // clamp the reference date into a real calendar date
   always_comb begin
      if (req_in_month == 4'd0) begin
         month_c = 4'd1;
      end else if (req_in_month > 4'd12) begin
         month_c = 4'd12;
      end else begin
         month_c = req_in_month;
      end
      lim        = days_of(req_in_year, month_c);
      clean.year  = req_in_year;
      clean.month = month_c;
      if (req_in_day == 5'd0) begin
         clean.day = 5'd1;
      end else if (req_in_day > lim) begin
         clean.day = lim;
      end else begin
         clean.day = req_in_day;
      end
   end

   always_comb begin
      accept     = start && (state_ff == ST_IDLE);
      gap_pos    = !req_day_gap[11] && (req_day_gap != 12'sd0);
      walk_end   = (rem_ff == 12'd0);
      walk_limit = (steps_ff == LIMIT);
      need_retry = (phase_ff == PH_FIRST) && mod_ff &&
                   ((cur_ff.month != ref_ff.month) || (cur_ff.year != ref_ff.year));
      wr_entry.valid = req_slot_valid;
      wr_entry.year  = req_in_year;
      wr_entry.month = req_in_month;
      wr_entry.day   = req_in_day;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (tbl_ready) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start && (req_opcode == OP_SHIFT)) begin
               state_in = ST_WALK;
            end else if (start && (req_opcode == OP_ROLL)) begin
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            if (scan.done) begin
               state_in = scan.hit ? ST_WALK : ST_IDLE;
            end
         end
         ST_WALK: begin
            priority if (walk_end) begin
               state_in = need_retry ? ST_WALK : ST_IDLE;
            end else if (walk_limit) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan.done) begin
               state_in = ST_WALK;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in      = phase_ff;
      cur_in        = cur_ff;
      ref_in        = ref_ff;
      fwd_in        = fwd_ff;
      mod_in        = mod_ff;
      rem_in        = rem_ff;
      steps_in      = steps_ff;
      rsp_valid_in  = 1'b0;
      rsp_date_in   = rsp_date_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      scan_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_opcode)
                  OP_WRITE_SLOT: begin
                     wr_en         = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_date_in   = '0;
                     rsp_status_in = STATUS_SLOT;
                  end
                  OP_SHIFT: begin
                     cur_in   = clean;
                     ref_in   = clean;
                     fwd_in   = gap_pos;
                     rem_in   = gap_pos ? $unsigned(req_day_gap) : $unsigned(-req_day_gap);
                     steps_in = '0;
                     phase_in = PH_SHIFT;
                  end
                  OP_ROLL: begin
                     cur_in     = clean;
                     ref_in     = clean;
                     fwd_in     = (req_convention == CONV_MOD_FOLLOWING) ||
                                  (req_convention == CONV_FOLLOWING);
                     mod_in     = (req_convention == CONV_MOD_FOLLOWING) ||
                                  (req_convention == CONV_MOD_PRECEDING);
                     phase_in   = PH_FIRST;
                     scan_start = 1'b1;
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_date_in   = clean;
                     rsp_status_in = STATUS_DONE;
                  end
               endcase
            end
         end
         ST_TEST: begin
            if (scan.done) begin
               if (scan.hit) begin
                  rem_in   = 12'd1;
                  steps_in = '0;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_date_in   = cur_ff;
                  rsp_status_in = STATUS_DONE;
               end
            end
         end
         ST_WALK: begin
            priority if (walk_end) begin
               if (need_retry) begin
                  // modified roll left the month: go the other way from the reference
                  cur_in   = ref_ff;
                  fwd_in   = !fwd_ff;
                  rem_in   = 12'd1;
                  steps_in = '0;
                  phase_in = PH_SECOND;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_date_in   = cur_ff;
                  rsp_status_in = STATUS_DONE;
               end
            end else if (walk_limit) begin
               rsp_valid_in  = 1'b1;
               rsp_date_in   = cur_ff;
               rsp_status_in = STATUS_LIMIT;
            end else begin
               cur_in     = step_next;
               steps_in   = steps_ff + SLW'(1);
               scan_start = 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan.done && !scan.hit) begin
               rem_in = rem_ff - 12'd1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         phase_ff     <= PH_SHIFT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      ref_ff        <= ref_in;
      fwd_ff        <= fwd_in;
      mod_ff        <= mod_in;
      rem_ff        <= rem_in;
      steps_ff      <= steps_in;
      rsp_date_ff   <= rsp_date_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_year  = rsp_date_ff.year;
   assign rsp_out_month = rsp_date_ff.month;
   assign rsp_out_day   = rsp_date_ff.day;
   assign rsp_status    = rsp_status_ff;

endmodule
